// ----- hw/rtl/scap_pkg.sv -----
// Shared types and constants for the calibrated servo angle-to-pulse block.
// Depends on nothing; every other file refers to it by scoped names.
package scap_pkg;

  typedef enum logic [1:0] {
    CMD_SET_CAL   = 2'd0,
    CMD_SET_PULSE = 2'd1,
    CMD_SET_ANGLE = 2'd2,
    CMD_CENTER    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [15:0] min_us;
    logic [15:0] center_us;
    logic [15:0] max_us;
    logic        reversed;
  } cal_entry_t;

  // Status of the angle interpolation unit, seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } ang_stat_t;

  localparam logic [15:0] PULSE_FLOOR_US  = 16'd500;
  localparam logic [15:0] PULSE_CEIL_US   = 16'd2500;
  localparam logic [15:0] RESET_CENTER_US = 16'd1500;

  localparam cal_entry_t CAL_RESET = '{
    min_us:    PULSE_FLOOR_US,
    center_us: RESET_CENTER_US,
    max_us:    PULSE_CEIL_US,
    reversed:  1'b0
  };

  localparam logic [14:0] ANGLE_FULL_CD = 15'd18000;
  localparam logic [14:0] ANGLE_HALF_CD = 15'd9000;

  // floor(2^32 / 9000); the quotient estimate is low by at most one.
  localparam int          RECIP_SHIFT = 32;
  localparam logic [18:0] RECIP_HALF  = 19'd477218;

endpackage

// ----- hw/rtl/servo_angle_to_pulse_calibrated.sv -----
// Top level of the calibrated servo angle-to-pulse block.
// Depends on scap_pkg, scap_cal_mem and scap_angle_calc.

// The block keeps one calibration entry per servo (minimum, center and maximum
// pulse in microseconds plus a reversed-direction flag) in a small synchronous
// memory and turns each command transaction into PWM compare updates on the
// result channel. Set calibration writes the entry and produces no result;
// set pulse and set angle produce one result with last high; all-to-center
// produces NUM_SERVOS results, channel 0 first, with last high on the final
// one. An id at or above NUM_SERVOS is dropped silently. Entries that were
// never written read as 500/1500/2500 us, not reversed, from reset on, so no
// clearing pass is needed. The block works on one command at a time: set
// calibration and dropped commands finish at acceptance, set pulse passes
// through the fetch and emit states to a valid result, set angle also waits
// in the calculation state while the interpolation runs through a six-step
// multiply-and-divide unit, and all-to-center passes through fetch and emit
// once per servo, using the single memory read port feeding one result
// register. A full result register that is not taken holds the sequencer until out_ready rises.
module servo_angle_to_pulse_calibrated #(
  parameter int NUM_SERVOS = 5
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_servo_id,
  input  logic signed [16:0] in_angle_centideg,
  input  logic [15:0]        in_pulse_us,
  input  logic [15:0]        in_cal_min_us,
  input  logic [15:0]        in_cal_center_us,
  input  logic [15:0]        in_cal_max_us,
  input  logic               in_dir_negative,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel,
  output logic [15:0]        out_compare_us,
  output logic               out_last
);

  localparam int AW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CALC  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Clamp to the absolute servo range, then to the calibrated range with
  // the bounds put in order first.
  function automatic logic [15:0] limit_pulse(input logic [15:0] p_in,
                                              input logic [15:0] lo_in,
                                              input logic [15:0] hi_in);
    logic [15:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    p  = p_in;
    lo = lo_in;
    hi = hi_in;
    if (p < scap_pkg::PULSE_FLOOR_US) p = scap_pkg::PULSE_FLOOR_US;
    if (p > scap_pkg::PULSE_CEIL_US)  p = scap_pkg::PULSE_CEIL_US;
    if (lo > hi) begin
      lo = hi_in;
      hi = lo_in;
    end
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    return p;
  endfunction

  state_t               state_r, state_nxt;
  scap_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic signed [16:0]   angle_r;
  logic [15:0]          pulse_in_r;
  logic [15:0]          pulse_r, pulse_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           out_channel_r;
  logic [15:0]          out_compare_us_r;
  logic                 out_last_r;

  scap_pkg::cmd_t       cmd_in;
  logic                 in_fire;
  logic                 id_ok;
  logic                 last_idx;
  logic                 out_load;

  logic                 wr_en;
  scap_pkg::cal_entry_t wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  scap_pkg::cal_entry_t rd_data;

  logic                 ang_start;
  scap_pkg::ang_stat_t  ang_stat;
  logic [15:0]          ang_pulse;

  assign cmd_in   = scap_pkg::cmd_t'(in_cmd);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign id_ok    = (in_servo_id < 8'(NUM_SERVOS));
  assign last_idx = (idx_r == AW'(NUM_SERVOS - 1));
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Calibration writes happen at acceptance. Commands run one at a time, so
  // a read of an entry always comes at a later edge than its write and the
  // memory needs no forwarding path.
  assign wr_en   = in_fire && (cmd_in == scap_pkg::CMD_SET_CAL) && id_ok;
  assign wr_data = '{
    min_us:    in_cal_min_us,
    center_us: in_cal_center_us,
    max_us:    in_cal_max_us,
    reversed:  in_dir_negative
  };

  assign ang_start = (state_r == S_FETCH) && (cmd_r == scap_pkg::CMD_SET_ANGLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    pulse_nxt     = pulse_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = cmd_in;
          if (cmd_in == scap_pkg::CMD_CENTER) begin
            idx_nxt   = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_FETCH;
          end else if (cmd_in != scap_pkg::CMD_SET_CAL && id_ok) begin
            idx_nxt   = in_servo_id[AW-1:0];
            rd_en     = 1'b1;
            rd_addr   = in_servo_id[AW-1:0];
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (cmd_r == scap_pkg::CMD_SET_ANGLE) begin
          state_nxt = S_CALC;
        end else begin
          pulse_nxt = (cmd_r == scap_pkg::CMD_SET_PULSE) ? pulse_in_r
                                                         : rd_data.center_us;
          state_nxt = S_EMIT;
        end
      end
      S_CALC: begin
        if (ang_stat.done) begin
          pulse_nxt = ang_pulse;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (cmd_r == scap_pkg::CMD_CENTER && !last_idx) begin
            idx_nxt   = idx_r + AW'(1);
            rd_en     = 1'b1;
            rd_addr   = idx_r + AW'(1);
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    pulse_r <= pulse_nxt;
    if (in_fire) begin
      angle_r    <= in_angle_centideg;
      pulse_in_r <= in_pulse_us;
    end
    if (out_load) begin
      out_channel_r    <= 4'(idx_r);
      out_compare_us_r <= limit_pulse(pulse_r, rd_data.min_us, rd_data.max_us);
      out_last_r       <= (cmd_r != scap_pkg::CMD_CENTER) || last_idx;
    end
  end

  scap_cal_mem #(
    .DEPTH (NUM_SERVOS),
    .AW    (AW)
  ) u_cal_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_servo_id[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scap_angle_calc u_angle_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (ang_start),
    .angle_centideg (angle_r),
    .cal            (rd_data),
    .stat           (ang_stat),
    .pulse_us       (ang_pulse)
  );

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_compare_us = out_compare_us_r;
  assign out_last       = out_last_r;

  // The interpolation result is only expected while the sequencer waits on it.
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ang_stat.done |-> (state_r == S_CALC))
    else $error("angle result outside of the calculation wait");

  // A new transaction is never taken while the interpolation unit is busy.
  a_idle_unit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !ang_stat.busy)
    else $error("transaction accepted while the angle unit is busy");

  // Every memory read is followed by the fetch state that consumes it.
  a_read_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == S_FETCH))
    else $error("memory read data not consumed in the fetch state");

  // A result loaded in the emit state shows up on the result channel.
  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("emit step did not fill the result register");

endmodule

// ----- hw/rtl/scap_cal_mem.sv -----
// Calibration memory: one synchronous write port, one registered read port.
// Per-entry valid bits make unwritten entries read as the reset calibration.
// Depends on scap_pkg.
module scap_cal_mem #(
  parameter int DEPTH = 5,
  parameter int AW    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  scap_pkg::cal_entry_t  wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output scap_pkg::cal_entry_t  rd_data
);

  scap_pkg::cal_entry_t mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  scap_pkg::cal_entry_t rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : scap_pkg::CAL_RESET;

endmodule

// ----- hw/rtl/scap_angle_calc.sv -----
// Piecewise-linear angle-to-pulse interpolation, six registered steps.
// Divides by 9000 through a reciprocal multiply with one correction step.
// Depends on scap_pkg.
module scap_angle_calc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [16:0]    angle_centideg,
  input  scap_pkg::cal_entry_t  cal,
  output scap_pkg::ang_stat_t   stat,
  output logic [15:0]           pulse_us
);

  logic [5:0]  vld_r;

  logic [14:0] a_cl;
  logic [15:0] d_s;
  logic [15:0] d_abs;
  logic [16:0] span;
  logic [16:0] span_abs;

  logic [15:0] span_mag_r;
  logic [13:0] d_mag_r;
  logic        neg_r;
  logic [15:0] center_r;
  logic [29:0] m_r;
  logic [29:0] m2_r;
  logic [29:0] m3_r;
  logic [15:0] q0_r;
  logic [15:0] q0b_r;
  logic [29:0] qm_r;
  logic [15:0] q_r;
  logic [15:0] res_r;

  logic [48:0] qp;
  logic [29:0] rem;
  logic [17:0] sum;

  // Step 0: clamp, center and mirror the angle, pick the half-span.
  always_comb begin
    if (angle_centideg[16]) begin
      a_cl = '0;
    end else if (angle_centideg[15:0] > {1'b0, scap_pkg::ANGLE_FULL_CD}) begin
      a_cl = scap_pkg::ANGLE_FULL_CD;
    end else begin
      a_cl = angle_centideg[14:0];
    end
    d_s = {1'b0, a_cl} - {1'b0, scap_pkg::ANGLE_HALF_CD};
    if (cal.reversed) begin
      d_s = -d_s;
    end
    d_abs = d_s[15] ? -d_s : d_s;
    if (d_s[15]) begin
      span = {1'b0, cal.center_us} - {1'b0, cal.min_us};
    end else begin
      span = {1'b0, cal.max_us} - {1'b0, cal.center_us};
    end
    span_abs = span[16] ? -span : span;
  end

  assign qp  = 49'(m2_r) * 49'(scap_pkg::RECIP_HALF);
  assign rem = m3_r - qm_r;
  assign sum = neg_r ? ({2'b00, center_r} - {2'b00, q_r})
                     : ({2'b00, center_r} + {2'b00, q_r});

  always_ff @(posedge clk) begin
    if (start) begin
      span_mag_r <= span_abs[15:0];
      d_mag_r    <= d_abs[13:0];
      neg_r      <= span[16] ^ d_s[15];
      center_r   <= cal.center_us;
    end
    if (vld_r[0]) begin
      m_r <= 30'(span_mag_r) * 30'(d_mag_r);
    end
    if (vld_r[1]) begin
      m2_r <= m_r;
    end
    if (vld_r[2]) begin
      q0_r <= qp[scap_pkg::RECIP_SHIFT +: 16];
      m3_r <= m2_r;
    end
    if (vld_r[3]) begin
      qm_r  <= 30'(q0_r) * 30'(scap_pkg::ANGLE_HALF_CD);
      q0b_r <= q0_r;
    end
    if (vld_r[4]) begin
      q_r <= (rem >= 30'(scap_pkg::ANGLE_HALF_CD)) ? q0b_r + 16'd1 : q0b_r;
    end
    if (vld_r[5]) begin
      res_r <= sum[17] ? 16'd0 : sum[15:0];
    end
  end

  // One valid bit per step; the result register loads on the last one.
  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[4:0], start};
      done_r <= vld_r[5];
    end
  end

  assign stat.busy = |vld_r;
  assign stat.done = done_r;
  assign pulse_us  = res_r;

endmodule
